// ----- rtl/lcdnw_pkg.sv -----
`default_nettype none

package lcdnw_pkg;

    // Input item actions.
    localparam logic [1:0] ACT_INIT     = 2'd0;
    localparam logic [1:0] ACT_COMMAND  = 2'd1;
    localparam logic [1:0] ACT_DATA     = 2'd2;
    localparam logic [1:0] ACT_POSITION = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PULSE_WAIT   = 3'd0;
    localparam logic [2:0] CFG_COMMAND_WAIT = 3'd1;
    localparam logic [2:0] CFG_CLEAR_WAIT   = 3'd2;
    localparam logic [2:0] CFG_POWER_WAIT   = 3'd3;
    localparam logic [2:0] CFG_NIBBLE_WAIT  = 3'd4;

    // Register reset values.
    localparam logic [7:0]  PULSE_WAIT_RST   = 8'd1;
    localparam logic [15:0] COMMAND_WAIT_RST = 16'd40;
    localparam logic [15:0] CLEAR_WAIT_RST   = 16'd2000;
    localparam logic [15:0] POWER_WAIT_RST   = 16'd15000;
    localparam logic [15:0] NIBBLE_WAIT_RST  = 16'd4000;

    // Display bytes with special meaning.
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_SET_ADDRESS = 8'h80;

    // Function-set nibbles of the power-up sequence.
    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;

    // Last step of each sequencer phase and last power-up index.
    localparam logic [1:0] NIB_LAST_STEP  = 2'd2;
    localparam logic [2:0] BYTE_LAST_STEP = 3'd5;
    localparam logic [1:0] INIT_LAST_IDX  = 2'd3;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] value;
        logic [5:0] column;
        logic [1:0] row;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  port;
        logic [15:0] hold_us;
        logic        last;
    } t_out_item;

    // Kind of port write that the sequencer asks for.
    typedef enum logic [1:0] {
        KIND_POWER,
        KIND_NIBBLE,
        KIND_BYTE
    } t_kind;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       emit;
        t_kind      kind;
        logic [2:0] step;
        logic [1:0] idx;
        logic       init;
        logic       last;
    } t_cmd;

    // DDRAM offset of each display row.
    function automatic logic [6:0] row_offset(input logic [1:0] row);
        logic [6:0] off;
        case (row)
            2'd0:    off = 7'h00;
            2'd1:    off = 7'h40;
            2'd2:    off = 7'h14;
            default: off = 7'h54;
        endcase
        return off;
    endfunction

    // Command bytes sent at the end of initialization.
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h28;
            2'd1:    b = 8'h0C;
            2'd2:    b = 8'h06;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

    // Port byte layout: nibble in bits 7..4, enable in bit 2, select in bit 0.
    function automatic logic [7:0] port_byte(input logic [3:0] nib, input logic en,
                                             input logic rs);
        return {nib, 1'b0, en, 1'b0, rs};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lcdnw_ctrl.sv -----
`default_nettype none

module lcdnw_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire logic            i_is_init,
    output logic                 busy,
    output lcdnw_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POWER,
        ST_NIBBLE,
        ST_BYTE
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [1:0] r_idx, n_idx;
    logic       r_init, n_init;
    logic       accept;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // Walk the power-up sequence or a single byte, one port write per cycle.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_idx   = r_idx;
        n_init  = r_init;

        o_cmd      = '0;
        o_cmd.load = accept;
        o_cmd.kind = lcdnw_pkg::KIND_POWER;
        o_cmd.step = r_step;
        o_cmd.idx  = r_idx;
        o_cmd.init = r_init;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_step = '0;
                    n_idx  = '0;
                    n_init = i_is_init;
                    n_state = i_is_init ? ST_POWER : ST_BYTE;
                end
            end
            ST_POWER: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = lcdnw_pkg::KIND_POWER;
                n_state = ST_NIBBLE;
                n_step  = '0;
                n_idx   = '0;
            end
            ST_NIBBLE: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = lcdnw_pkg::KIND_NIBBLE;
                if (r_step[1:0] == lcdnw_pkg::NIB_LAST_STEP) begin
                    n_step = '0;
                    if (r_idx == lcdnw_pkg::INIT_LAST_IDX) begin
                        n_idx   = '0;
                        n_state = ST_BYTE;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_BYTE: begin
                o_cmd.emit = 1'b1;
                o_cmd.kind = lcdnw_pkg::KIND_BYTE;
                if (r_step == lcdnw_pkg::BYTE_LAST_STEP) begin
                    n_step = '0;
                    if (r_init && (r_idx != lcdnw_pkg::INIT_LAST_IDX)) begin
                        n_idx = r_idx + 2'd1;
                    end else begin
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
            r_init  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_init  <= n_init;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lcdnw_dp.sv -----
`default_nettype none

module lcdnw_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lcdnw_pkg::t_cmd                     i_cmd,
    input  wire lcdnw_pkg::t_in_item                 i_in,
    input  wire logic                                i_cfg_we,
    input  wire logic [lcdnw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lcdnw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                     o_is_init,
    output logic                                     o_strobe,
    output lcdnw_pkg::t_out_item                     o_out
);

    logic [7:0]  r_pulse_wait;
    logic [15:0] r_command_wait;
    logic [15:0] r_clear_wait;
    logic [15:0] r_power_wait;
    logic [15:0] r_nibble_wait;

    logic [7:0]  r_byte;
    logic        r_rs;
    logic        r_is_clear;
    logic        r_strobe;
    lcdnw_pkg::t_out_item r_out;

    logic [6:0]  pos_addr;
    logic [7:0]  in_byte;
    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic        cur_clear;
    logic [15:0] end_wait;
    logic [16:0] wait_sum;
    logic [15:0] wait_sat;
    logic [3:0]  cur_nib;
    lcdnw_pkg::t_out_item n_out;

    assign o_is_init = (i_in.action == lcdnw_pkg::ACT_INIT);

    // Byte for a command, data or cursor position item.
    assign pos_addr = lcdnw_pkg::row_offset(i_in.row) + {1'b0, i_in.column};
    assign in_byte  = (i_in.action == lcdnw_pkg::ACT_POSITION)
                    ? (lcdnw_pkg::CMD_SET_ADDRESS | {1'b0, pos_addr})
                    : i_in.value;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_wait   <= lcdnw_pkg::PULSE_WAIT_RST;
            r_command_wait <= lcdnw_pkg::COMMAND_WAIT_RST;
            r_clear_wait   <= lcdnw_pkg::CLEAR_WAIT_RST;
            r_power_wait   <= lcdnw_pkg::POWER_WAIT_RST;
            r_nibble_wait  <= lcdnw_pkg::NIBBLE_WAIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lcdnw_pkg::CFG_PULSE_WAIT:   r_pulse_wait   <= i_cfg_data[7:0];
                lcdnw_pkg::CFG_COMMAND_WAIT: r_command_wait <= i_cfg_data;
                lcdnw_pkg::CFG_CLEAR_WAIT:   r_clear_wait   <= i_cfg_data;
                lcdnw_pkg::CFG_POWER_WAIT:   r_power_wait   <= i_cfg_data;
                lcdnw_pkg::CFG_NIBBLE_WAIT:  r_nibble_wait  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Capture the item's byte and its register select when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte     <= in_byte;
            r_rs       <= (i_in.action == lcdnw_pkg::ACT_DATA);
            r_is_clear <= (i_in.action == lcdnw_pkg::ACT_COMMAND)
                       && (i_in.value == lcdnw_pkg::CMD_CLEAR);
        end
    end

    // Byte being sent: a power-up command or the captured one.
    assign cur_byte  = i_cmd.init ? lcdnw_pkg::init_byte(i_cmd.idx) : r_byte;
    assign cur_rs    = i_cmd.init ? 1'b0 : r_rs;
    assign cur_clear = i_cmd.init ? (i_cmd.idx == lcdnw_pkg::INIT_LAST_IDX) : r_is_clear;

    // Wait after the closing write, saturated at the field's range.
    always_comb begin
        if (i_cmd.kind == lcdnw_pkg::KIND_NIBBLE) begin
            end_wait = r_nibble_wait;
        end else if (cur_clear) begin
            end_wait = r_clear_wait;
        end else begin
            end_wait = r_command_wait;
        end
    end
    assign wait_sum = {9'd0, r_pulse_wait} + {1'b0, end_wait};
    assign wait_sat = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];

    assign cur_nib = (i_cmd.idx == lcdnw_pkg::INIT_LAST_IDX)
                   ? lcdnw_pkg::NIB_4BIT : lcdnw_pkg::NIB_WAKE;

    // Port byte and hold time for the requested write.
    always_comb begin
        n_out      = '0;
        n_out.last = i_cmd.last;
        case (i_cmd.kind)
            lcdnw_pkg::KIND_POWER: begin
                n_out.port    = '0;
                n_out.hold_us = r_power_wait;
            end
            lcdnw_pkg::KIND_NIBBLE: begin
                case (i_cmd.step[1:0])
                    2'd0: begin
                        n_out.port    = lcdnw_pkg::port_byte(cur_nib, 1'b0, 1'b0);
                        n_out.hold_us = '0;
                    end
                    2'd1: begin
                        n_out.port    = lcdnw_pkg::port_byte(cur_nib, 1'b1, 1'b0);
                        n_out.hold_us = {8'd0, r_pulse_wait};
                    end
                    default: begin
                        n_out.port    = lcdnw_pkg::port_byte(cur_nib, 1'b0, 1'b0);
                        n_out.hold_us = wait_sat;
                    end
                endcase
            end
            default: begin
                case (i_cmd.step)
                    3'd0, 3'd2: begin
                        n_out.port    = lcdnw_pkg::port_byte(cur_byte[7:4], 1'b0, cur_rs);
                        n_out.hold_us = {8'd0, r_pulse_wait};
                    end
                    3'd1: begin
                        n_out.port    = lcdnw_pkg::port_byte(cur_byte[7:4], 1'b1, cur_rs);
                        n_out.hold_us = {8'd0, r_pulse_wait};
                    end
                    3'd3: begin
                        n_out.port    = lcdnw_pkg::port_byte(cur_byte[3:0], 1'b0, cur_rs);
                        n_out.hold_us = '0;
                    end
                    3'd4: begin
                        n_out.port    = lcdnw_pkg::port_byte(cur_byte[3:0], 1'b1, cur_rs);
                        n_out.hold_us = {8'd0, r_pulse_wait};
                    end
                    default: begin
                        n_out.port    = lcdnw_pkg::port_byte(cur_byte[3:0], 1'b0, cur_rs);
                        n_out.hold_us = wait_sat;
                    end
                endcase
            end
        endcase
    end

    // Output register: each item is shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

`default_nettype wire

// ----- rtl/char_lcd_nibble_writer.sv -----
// Channel   Handshake                Payload
// input     start, accepted !busy    i_in  (action, value, column, row)
// result    o_strobe, one cycle      o_out (port, hold_us, last)
// config    i_cfg_we, no wait        i_cfg_index, i_cfg_data
//
// A command, data or cursor item gives 6 results, initialization 37, one per
// cycle; the first reaches the ports through the state register and then the
// output register. A new item may start in the cycle busy falls, so the block
// takes no new item before it is through with the last one.
// Reset is synchronous and active low; it restores the register defaults.
// The receiver cannot stall: every result is valid for exactly one cycle.
`default_nettype none

module char_lcd_nibble_writer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire lcdnw_pkg::t_in_item                 i_in,
    output logic                                     o_strobe,
    output lcdnw_pkg::t_out_item                     o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [lcdnw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lcdnw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    lcdnw_pkg::t_cmd cmd;
    logic            is_init;

    // Sequencer.
    lcdnw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_is_init (is_init),
        .busy      (busy),
        .o_cmd     (cmd)
    );

    // Registers, byte capture and port formatting.
    lcdnw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_is_init   (is_init),
        .o_strobe    (o_strobe),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT      = 400;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int TAIL_CYCLES     = 20;

    localparam logic [7:0]  E_BIT     = 8'h04;
    localparam logic [7:0]  RS_BIT    = 8'h01;
    // Row offsets, row 0 in the low byte.
    localparam logic [31:0] ROW_BASES = {8'h54, 8'h14, 8'h40, 8'h00};
    // Closing commands of the power-up sequence, first one in the high byte.
    localparam logic [31:0] INIT_CMDS = {8'h28, 8'h0C, 8'h06, lcdnw_pkg::CMD_CLEAR};

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             start       = 1'b0;
    logic                             busy;
    lcdnw_pkg::t_in_item              i_in        = '0;
    logic                             o_strobe;
    lcdnw_pkg::t_out_item             o_out;
    logic                             i_cfg_we    = 1'b0;
    logic [lcdnw_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lcdnw_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Timing registers as the block should hold them.
    logic [7:0]  pulse_us   = lcdnw_pkg::PULSE_WAIT_RST;
    logic [15:0] command_us = lcdnw_pkg::COMMAND_WAIT_RST;
    logic [15:0] clear_us   = lcdnw_pkg::CLEAR_WAIT_RST;
    logic [15:0] power_us   = lcdnw_pkg::POWER_WAIT_RST;
    logic [15:0] nibble_us  = lcdnw_pkg::NIBBLE_WAIT_RST;

    lcdnw_pkg::t_in_item  lcd_items_todo[$];
    lcdnw_pkg::t_out_item lcd_writes_due[$];

    int   n_errors    = 0;
    int   idle_cycles = 0;
    int   burst_left  = 0;
    int   gap_left    = 0;
    logic drain_hold  = 1'b0;

    char_lcd_nibble_writer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Pulse wait plus a longer wait, saturated to 16 bits.
    function automatic logic [15:0] pulse_plus(input logic [15:0] w);
        logic [16:0] s;
        s = {9'd0, pulse_us} + {1'b0, w};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void push_write(input logic [7:0] port, input logic [15:0] hold);
        lcdnw_pkg::t_out_item w;
        w.port    = port;
        w.hold_us = hold;
        w.last    = 1'b0;
        lcd_writes_due.push_back(w);
    endfunction

    // One power-up nibble: enable low, high, low.
    function automatic void push_init_nibble(input logic [3:0] nib);
        logic [7:0] d;
        d = {nib, 4'h0};
        push_write(d, 16'd0);
        push_write(d | E_BIT, {8'd0, pulse_us});
        push_write(d, pulse_plus(nibble_us));
    endfunction

    // A whole byte as high then low nibble, six port writes.
    function automatic void push_byte(input logic rs, input logic [7:0] b,
                                      input logic [15:0] wait_us);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {b[7:4], 4'h0} | (rs ? RS_BIT : 8'h00);
        lo = {b[3:0], 4'h0} | (rs ? RS_BIT : 8'h00);
        push_write(hi, {8'd0, pulse_us});
        push_write(hi | E_BIT, {8'd0, pulse_us});
        push_write(hi, {8'd0, pulse_us});
        push_write(lo, 16'd0);
        push_write(lo | E_BIT, {8'd0, pulse_us});
        push_write(lo, pulse_plus(wait_us));
    endfunction

    // Work out every port write that one accepted item causes.
    function automatic void predict_port_writes(input lcdnw_pkg::t_in_item it);
        logic [7:0] b;
        logic [6:0] addr;
        case (it.action)
            lcdnw_pkg::ACT_INIT: begin
                push_write(8'h00, power_us);
                for (int i = 0; i < 3; i++) push_init_nibble(lcdnw_pkg::NIB_WAKE);
                push_init_nibble(lcdnw_pkg::NIB_4BIT);
                for (int i = 0; i < 4; i++) begin
                    b = INIT_CMDS[8*(3-i) +: 8];
                    push_byte(1'b0, b, (b == lcdnw_pkg::CMD_CLEAR) ? clear_us : command_us);
                end
            end
            lcdnw_pkg::ACT_COMMAND: begin
                push_byte(1'b0, it.value,
                          (it.value == lcdnw_pkg::CMD_CLEAR) ? clear_us : command_us);
            end
            lcdnw_pkg::ACT_DATA: begin
                push_byte(1'b1, it.value, command_us);
            end
            default: begin
                b    = ROW_BASES[8*it.row +: 8];
                addr = b[6:0] + {1'b0, it.column};
                push_byte(1'b0, lcdnw_pkg::CMD_SET_ADDRESS | {1'b0, addr}, command_us);
            end
        endcase
        lcd_writes_due[lcd_writes_due.size()-1].last = 1'b1;
    endfunction

    // Item driver: bursts of random length, random gaps, and now and then a
    // pause until every expected port write has come back.
    always @(posedge i_clk) begin
        logic taken;
        logic go;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) predict_port_writes(i_in);
            if (!start || taken) begin
                go = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (drain_hold) begin
                    if (lcd_writes_due.size() == 0) drain_hold = 1'b0;
                end else if (lcd_items_todo.size() != 0) begin
                    go = 1'b1;
                end
                if (go) begin
                    i_in <= lcd_items_todo.pop_front();
                    if (burst_left == 0) burst_left = $urandom_range(1, 16);
                    burst_left--;
                    if (burst_left == 0) begin
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(10, 40);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                        drain_hold = ($urandom_range(0, 7) == 0);
                    end
                end
                start <= go;
            end
        end
    end

    // Result monitor: every strobed port write against the oldest expectation.
    always @(posedge i_clk) begin
        lcdnw_pkg::t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (lcd_writes_due.size() == 0) begin
                $error("unexpected port write: port %h hold_us %0d last %0b",
                       o_out.port, o_out.hold_us, o_out.last);
                n_errors++;
            end else begin
                want = lcd_writes_due.pop_front();
                if (o_out.port !== want.port) begin
                    $error("port: expected %h, actual %h", want.port, o_out.port);
                    n_errors++;
                end
                if (o_out.hold_us !== want.hold_us) begin
                    $error("hold_us: expected %0d, actual %0d", want.hold_us, o_out.hold_us);
                    n_errors++;
                end
                if (o_out.last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_out.last);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on cycles where nothing moves on any port.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_item(input logic [1:0] action, input logic [7:0] value,
                              input logic [5:0] column, input logic [1:0] row);
        lcdnw_pkg::t_in_item it;
        it.action = action;
        it.value  = value;
        it.column = column;
        it.row    = row;
        lcd_items_todo.push_back(it);
    endtask

    // Wait until every item is taken and every port write has come back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (lcd_items_todo.size() != 0 || start || busy || lcd_writes_due.size() != 0);
        @(posedge i_clk);
    endtask

    // Caller is just past a rising edge; the write lands on the next one.
    task automatic write_reg(input logic [lcdnw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lcdnw_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            lcdnw_pkg::CFG_PULSE_WAIT:   pulse_us   = data[7:0];
            lcdnw_pkg::CFG_COMMAND_WAIT: command_us = data;
            lcdnw_pkg::CFG_CLEAR_WAIT:   clear_us   = data;
            lcdnw_pkg::CFG_POWER_WAIT:   power_us   = data;
            lcdnw_pkg::CFG_NIBBLE_WAIT:  nibble_us  = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Write all five registers, plus junk to the unused indexes.
    task automatic set_timing(input logic [15:0] pulse, input logic [15:0] cmd,
                              input logic [15:0] clr, input logic [15:0] pwr,
                              input logic [15:0] nib);
        write_reg(lcdnw_pkg::CFG_PULSE_WAIT, pulse);
        write_reg(lcdnw_pkg::CFG_COMMAND_WAIT, cmd);
        write_reg(lcdnw_pkg::CFG_CLEAR_WAIT, clr);
        write_reg(lcdnw_pkg::CFG_POWER_WAIT, pwr);
        write_reg(lcdnw_pkg::CFG_NIBBLE_WAIT, nib);
        for (int idx = int'(lcdnw_pkg::CFG_NIBBLE_WAIT) + 1;
             idx < (1 << lcdnw_pkg::CFG_IDX_W); idx++) begin
            write_reg(lcdnw_pkg::CFG_IDX_W'(idx), lcdnw_pkg::CFG_DATA_W'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly random waits, with the extremes mixed in.
    function automatic logic [15:0] pick_wait();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        lcdnw_pkg::t_in_item it;
        int r;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset timing.
        queue_item(lcdnw_pkg::ACT_INIT, 8'h00, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_COMMAND, lcdnw_pkg::CMD_CLEAR, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_COMMAND, 8'h00, 6'd63, 2'd3);
        queue_item(lcdnw_pkg::ACT_COMMAND, 8'hFF, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_DATA, lcdnw_pkg::CMD_CLEAR, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_DATA, 8'h00, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_DATA, 8'hFF, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_POSITION, 8'h00, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_POSITION, 8'hFF, 6'd39, 2'd1);
        queue_item(lcdnw_pkg::ACT_POSITION, 8'h01, 6'd20, 2'd2);
        queue_item(lcdnw_pkg::ACT_POSITION, 8'h00, 6'd39, 2'd3);
        // Columns past the display wrap inside the 7-bit address.
        queue_item(lcdnw_pkg::ACT_POSITION, 8'h00, 6'd63, 2'd3);
        queue_item(lcdnw_pkg::ACT_POSITION, 8'h00, 6'd63, 2'd1);
        queue_item(lcdnw_pkg::ACT_COMMAND, lcdnw_pkg::CMD_SET_ADDRESS, 6'd0, 2'd0);
        wait_drained();

        // All waits zero.
        set_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_item(lcdnw_pkg::ACT_INIT, 8'hFF, 6'd63, 2'd3);
        queue_item(lcdnw_pkg::ACT_COMMAND, lcdnw_pkg::CMD_CLEAR, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_DATA, 8'h5A, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_POSITION, 8'h00, 6'd45, 2'd2);
        wait_drained();

        // All waits at maximum, so every closing hold saturates.
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_item(lcdnw_pkg::ACT_INIT, 8'h00, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_COMMAND, lcdnw_pkg::CMD_CLEAR, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_COMMAND, 8'h28, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_DATA, 8'hFF, 6'd0, 2'd0);
        queue_item(lcdnw_pkg::ACT_POSITION, 8'hA5, 6'd0, 2'd0);
        wait_drained();

        // Random phases, each with its own timing.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_timing(pick_wait(), pick_wait(), pick_wait(), pick_wait(), pick_wait());
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < 4) it.action = lcdnw_pkg::ACT_INIT;
                else if (r < 36) it.action = lcdnw_pkg::ACT_COMMAND;
                else if (r < 68) it.action = lcdnw_pkg::ACT_DATA;
                else it.action = lcdnw_pkg::ACT_POSITION;
                it.value = 8'($urandom_range(0, 255));
                if (it.action == lcdnw_pkg::ACT_COMMAND && $urandom_range(0, 7) == 0)
                    it.value = lcdnw_pkg::CMD_CLEAR;
                if ($urandom_range(0, 5) == 0) it.column = 6'($urandom_range(40, 63));
                else it.column = 6'($urandom_range(0, 39));
                it.row = 2'($urandom_range(0, 3));
                lcd_items_todo.push_back(it);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (lcd_writes_due.size() != 0) begin
            $error("%0d expected port writes never arrived", lcd_writes_due.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
